>>> sv/glr_pkg.sv
// Shared constants and types for the graph Laplacian row engine.
// Used by the front end, the row descriptor queue, the back end and the top level.
package glr_pkg;

    // Matrix size limit and derived widths
    localparam int MAX_NODES    = 32;
    localparam int IDX_W        = $clog2(MAX_NODES);
    localparam int NODE_COUNT_W = 6;
    localparam int WEIGHT_W     = 16;
    localparam int VALUE_W      = 22;
    localparam int DEG_W        = WEIGHT_W + IDX_W;
    localparam int REM_W        = DEG_W + 1;
    localparam int QUOT_W       = 16;

    // Row buffer: two banks so one row fills while the previous one drains
    localparam int NUM_BANKS    = 2;
    localparam int BUF_AW       = IDX_W + 1;
    localparam int BUF_DEPTH    = NUM_BANKS * MAX_NODES;

    // Descriptor queue holds one entry per bank
    localparam int Q_DEPTH      = NUM_BANKS;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    // Radix of the ratio divider: quotient bits resolved per cycle
    localparam int DIV_STEPS    = 4;
    localparam int DIV_CYCLES   = QUOT_W / DIV_STEPS;
    localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

    // Configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = NODE_COUNT_W;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = CFG_IDX_W'(1);
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = NODE_COUNT_W'(32);

    // Operating modes
    localparam logic MODE_COMB = 1'b0;
    localparam logic MODE_RW   = 1'b1;

    // One completed row, handed from front to back
    typedef struct packed {
        logic              bank;
        logic              mode;
        logic [DEG_W-1:0]  degree;
        logic [IDX_W-1:0]  diag;
        logic [IDX_W-1:0]  last_col;
        logic              last_row;
    } row_desc_t;

    // Row buffer write request from the front end
    typedef struct packed {
        logic                en;
        logic [BUF_AW-1:0]   addr;
        logic [WEIGHT_W-1:0] data;
    } buf_wr_t;

endpackage

>>> sv/glr_front.sv
// Front end: accepts weights, holds configuration, fills the row buffer and
// sums the degree; posts a descriptor per completed row. Depends on glr_pkg.
module glr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [glr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [glr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [glr_pkg::WEIGHT_W-1:0]      weight,
    input  logic                              q_full,
    output logic                              q_push,
    output glr_pkg::row_desc_t                q_push_data,
    output glr_pkg::buf_wr_t                  buf_wr
);

    // Clamp node_count to 1..MAX_NODES and return the last column index
    function automatic logic [glr_pkg::IDX_W-1:0] last_col_of(
        input logic [glr_pkg::NODE_COUNT_W-1:0] nc
    );
        logic [glr_pkg::IDX_W-1:0] lc;
        if (nc == '0)
        begin
            lc = '0;
        end
        else if (int'(nc) > glr_pkg::MAX_NODES)
        begin
            lc = glr_pkg::IDX_W'(glr_pkg::MAX_NODES - 1);
        end
        else
        begin
            lc = glr_pkg::IDX_W'(int'(nc) - 1);
        end
        return lc;
    endfunction

    logic [glr_pkg::NODE_COUNT_W-1:0] node_count_reg, node_count_next;
    logic                             mode_reg, mode_next;
    logic [glr_pkg::IDX_W-1:0]        col_reg, col_next;
    logic [glr_pkg::IDX_W-1:0]        row_reg, row_next;
    logic [glr_pkg::DEG_W-1:0]        deg_reg, deg_next;
    logic                             bank_reg, bank_next;

    logic                             accept;
    logic                             row_done;
    logic                             last_row;
    logic [glr_pkg::IDX_W-1:0]        last_col;
    logic [glr_pkg::DEG_W-1:0]        deg_sum;

    // Classify the incoming transaction
    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign last_col = last_col_of(node_count_reg);
    assign deg_sum  = deg_reg + glr_pkg::DEG_W'(weight);
    assign row_done = accept && (col_reg == last_col);
    assign last_row = (row_reg == last_col);

    // Write the weight into the current bank
    assign buf_wr.en   = accept;
    assign buf_wr.addr = {bank_reg, col_reg};
    assign buf_wr.data = weight;

    // Post the completed row
    assign q_push               = row_done;
    assign q_push_data.bank     = bank_reg;
    assign q_push_data.mode     = mode_reg;
    assign q_push_data.degree   = deg_sum;
    assign q_push_data.diag     = row_reg;
    assign q_push_data.last_col = last_col;
    assign q_push_data.last_row = last_row;

    // Advance counters; a node_count write restarts the stream
    always_comb
    begin
        node_count_next = node_count_reg;
        mode_next       = mode_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        deg_next        = deg_reg;
        bank_next       = bank_reg;
        if (accept)
        begin
            if (row_done)
            begin
                col_next  = '0;
                deg_next  = '0;
                bank_next = !bank_reg;
                row_next  = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
                deg_next = deg_sum;
            end
        end
        if (cfg_wr_en)
        begin
            case (cfg_index)
                glr_pkg::REG_NODE_COUNT:
                begin
                    node_count_next = cfg_data;
                    col_next        = '0;
                    row_next        = '0;
                    deg_next        = '0;
                end
                glr_pkg::REG_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Hold front state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= glr_pkg::NODE_COUNT_RESET;
            mode_reg       <= glr_pkg::MODE_COMB;
            col_reg        <= '0;
            row_reg        <= '0;
            deg_reg        <= '0;
            bank_reg       <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            mode_reg       <= mode_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            deg_reg        <= deg_next;
            bank_reg       <= bank_next;
        end
    end

endmodule

>>> sv/glr_queue.sv
// Row descriptor queue between front and back, one entry per buffer bank.
// Depends on glr_pkg.
module glr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  glr_pkg::row_desc_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output glr_pkg::row_desc_t head
);

    glr_pkg::row_desc_t               entry_reg [glr_pkg::Q_DEPTH];
    logic [glr_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [glr_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [glr_pkg::Q_CNT_W-1:0]      count_reg, count_next;

    assign full  = (count_reg == glr_pkg::Q_CNT_W'(glr_pkg::Q_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == glr_pkg::Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == glr_pkg::Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed descriptors
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("descriptor pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("descriptor popped from an empty queue");
`endif

endmodule

>>> sv/glr_back.sv
// Back end: owns the two-bank row buffer, emits one Laplacian element per
// column through a registered output stage, with a radix-16 ratio divider.
// Depends on glr_pkg.
module glr_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  glr_pkg::buf_wr_t                 buf_wr,
    input  logic                             q_valid,
    input  glr_pkg::row_desc_t               q_head,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [glr_pkg::VALUE_W-1:0]      out_value,
    output logic                             out_row_last,
    output logic                             out_matrix_last,
    output logic                             out_zero_degree
);

    localparam int EXT_W = (glr_pkg::DEG_W + 1 > glr_pkg::VALUE_W) ?
                           glr_pkg::DEG_W + 1 : glr_pkg::VALUE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_SEND
    } state_t;

    // Row buffer
    logic [glr_pkg::WEIGHT_W-1:0]  buf_mem [glr_pkg::BUF_DEPTH];
    logic [glr_pkg::WEIGHT_W-1:0]  rd_data_reg;
    logic [glr_pkg::BUF_AW-1:0]    rd_addr;

    state_t                        state_reg, state_next;
    glr_pkg::row_desc_t            desc_reg, desc_next;
    logic [glr_pkg::IDX_W-1:0]     col_reg, col_next;
    logic [glr_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [glr_pkg::QUOT_W-1:0]    quot_reg, quot_next;
    logic [glr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [glr_pkg::VALUE_W-1:0]   res_reg, res_next;
    logic                          zf_reg, zf_next;

    logic                          out_valid_reg, out_valid_next;
    logic [glr_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic                          row_last_reg, row_last_next;
    logic                          matrix_last_reg, matrix_last_next;
    logic                          zero_degree_reg, zero_degree_next;

    logic                          slot_free;
    logic                          last_col;
    logic [EXT_W-1:0]              diag_term;
    logic [EXT_W-1:0]              diff;
    logic [glr_pkg::REM_W-1:0]     rem_it;
    logic [glr_pkg::QUOT_W-1:0]    quot_it;
    logic [glr_pkg::REM_W-1:0]     divisor;

    assign slot_free = !out_valid_reg || out_ready;
    assign last_col  = (col_reg == desc_reg.last_col);
    assign rd_addr   = {desc_next.bank, col_next};

    // Combinatorial form: degree on the diagonal minus the weight
    assign diag_term = (col_reg == desc_reg.diag) ? EXT_W'(desc_reg.degree) : '0;
    assign diff      = diag_term - EXT_W'(rd_data_reg);
    assign divisor   = glr_pkg::REM_W'(desc_reg.degree);

    // Resolve DIV_STEPS quotient bits of weight * 2^16 / degree; a weight
    // equal to the degree runs to all ones, which is the saturated ratio
    always_comb
    begin
        rem_it  = rem_reg;
        quot_it = quot_reg;
        for (int i = 0; i < glr_pkg::DIV_STEPS; i++)
        begin
            rem_it = {rem_it[glr_pkg::REM_W-2:0], 1'b0};
            if (rem_it >= divisor)
            begin
                rem_it  = rem_it - divisor;
                quot_it = {quot_it[glr_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                quot_it = {quot_it[glr_pkg::QUOT_W-2:0], 1'b0};
            end
        end
    end

    // Sequence the columns of the current row
    always_comb
    begin
        state_next       = state_reg;
        desc_next        = desc_reg;
        col_next         = col_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        cnt_next         = cnt_reg;
        res_next         = res_reg;
        zf_next          = zf_reg;
        q_pop            = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        value_next       = value_reg;
        row_last_next    = row_last_reg;
        matrix_last_next = matrix_last_reg;
        zero_degree_next = zero_degree_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    desc_next  = q_head;
                    col_next   = '0;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (desc_reg.mode == glr_pkg::MODE_COMB)
                begin
                    res_next   = diff[glr_pkg::VALUE_W-1:0];
                    zf_next    = 1'b0;
                    state_next = S_SEND;
                end
                else if (desc_reg.degree == '0)
                begin
                    res_next   = '0;
                    zf_next    = 1'b1;
                    state_next = S_SEND;
                end
                else
                begin
                    rem_next   = glr_pkg::REM_W'(rd_data_reg);
                    quot_next  = '0;
                    cnt_next   = '0;
                    zf_next    = 1'b0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = rem_it;
                quot_next = quot_it;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == glr_pkg::DIV_CNT_W'(glr_pkg::DIV_CYCLES - 1))
                begin
                    res_next   = glr_pkg::VALUE_W'(quot_it);
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    value_next       = res_reg;
                    row_last_next    = last_col;
                    matrix_last_next = last_col && desc_reg.last_row;
                    zero_degree_next = zf_reg;
                    if (last_col)
                    begin
                        q_pop      = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = S_CALC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            desc_reg        <= '0;
            col_reg         <= '0;
            rem_reg         <= '0;
            quot_reg        <= '0;
            cnt_reg         <= '0;
            res_reg         <= '0;
            zf_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            value_reg       <= '0;
            row_last_reg    <= 1'b0;
            matrix_last_reg <= 1'b0;
            zero_degree_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            desc_reg        <= desc_next;
            col_reg         <= col_next;
            rem_reg         <= rem_next;
            quot_reg        <= quot_next;
            cnt_reg         <= cnt_next;
            res_reg         <= res_next;
            zf_reg          <= zf_next;
            out_valid_reg   <= out_valid_next;
            value_reg       <= value_next;
            row_last_reg    <= row_last_next;
            matrix_last_reg <= matrix_last_next;
            zero_degree_reg <= zero_degree_next;
        end
    end

    // Write from the front, registered read for the back
    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
        begin
            buf_mem[buf_wr.addr] <= buf_wr.data;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    assign out_valid       = out_valid_reg;
    assign out_value       = value_reg;
    assign out_row_last    = row_last_reg;
    assign out_matrix_last = matrix_last_reg;
    assign out_zero_degree = zero_degree_reg;

`ifndef SYNTH
    a_div_only_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (desc_reg.mode == glr_pkg::MODE_RW && desc_reg.degree != '0))
        else $error("divider running without a random-walk row of nonzero degree");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zero_degree_reg) |-> (value_reg == '0))
        else $error("zero-degree element carries a nonzero value");

    a_matrix_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && matrix_last_reg) |-> row_last_reg)
        else $error("matrix end flagged inside a row");

    a_pop_on_send: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == S_IDLE && out_valid_reg && row_last_reg))
        else $error("row released without emitting its last element");
`endif

endmodule

>>> sv/graph_laplacian_row_engine_top.sv
// Graph Laplacian row engine: input channel carries adjacency weights in
// row-major order (unsigned Q8.8); output channel carries one Laplacian
// element per column once a row is complete. Built from glr_front, glr_queue
// and glr_back; depends on glr_pkg.
//
// Configuration: cfg_wr_en/cfg_index/cfg_data write node_count (index 0) or
// mode (index 1); write only while the block is idle. A
// node_count write restarts the stream at row 0, column 0.
// Input: one weight per cycle is taken while a row buffer bank is free. Two
// banks let the next row fill while the previous one drains; in_ready drops
// only when both banks hold rows not yet emitted.
// Output: a completed row's descriptor passes through the queue; the back end
// takes it from idle, reads each column through the registered row buffer
// read, forms the element, in the random-walk mode with a nonzero degree
// through the ratio divider resolving 4 quotient bits per cycle, and loads it
// into the output register once that register is free. The next column
// starts only after the element is sent.
// Reset: asynchronous, clears all control state; the row buffer needs no
// clearing pass. A stalled out_ready holds the output register, which in
// turn holds the back end and, once both banks are full, in_ready.
module graph_laplacian_row_engine_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [glr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [glr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [glr_pkg::WEIGHT_W-1:0]          weight,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [glr_pkg::VALUE_W-1:0]    value,
    output logic                                  row_last,
    output logic                                  matrix_last,
    output logic                                  zero_degree
);

    logic                          q_full;
    logic                          q_push;
    logic                          q_pop;
    logic                          q_valid;
    glr_pkg::row_desc_t            q_push_data;
    glr_pkg::row_desc_t            q_head;
    glr_pkg::buf_wr_t              buf_wr;
    logic [glr_pkg::VALUE_W-1:0]   value_bits;

    // Accept and classify weights
    glr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .weight      (weight),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .buf_wr      (buf_wr)
    );

    // Decouple front and back
    glr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // Emit rows
    glr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .buf_wr          (buf_wr),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_value       (value_bits),
        .out_row_last    (row_last),
        .out_matrix_last (matrix_last),
        .out_zero_degree (zero_degree)
    );

    assign value = $signed(value_bits);

endmodule

>>> sim/graph_laplacian_row_engine_top_tb.sv
// Self-checking testbench for graph_laplacian_row_engine_top: a directed table and random
// matrix rows, checked element by element against a Laplacian row predictor.
// Depends on glr_pkg and the RTL of graph_laplacian_row_engine_top.
module graph_laplacian_row_engine_top_tb;

    localparam int STALL_LIMIT  = 4000;
    localparam int CFG_PAUSE    = 16;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_ITEMS   = 108;

    // Mode values as written through the configuration port
    localparam logic [glr_pkg::CFG_DATA_W-1:0] CFG_RW   =
        glr_pkg::CFG_DATA_W'(glr_pkg::MODE_RW);
    localparam logic [glr_pkg::CFG_DATA_W-1:0] CFG_COMB =
        glr_pkg::CFG_DATA_W'(glr_pkg::MODE_COMB);

    // One emitted Laplacian element
    typedef struct packed {
        logic signed [glr_pkg::VALUE_W-1:0] value;
        logic                               row_last;
        logic                               matrix_last;
        logic                               zero_degree;
    } lap_elem_t;

    typedef enum logic [1:0] {
        ST_CFG,
        ST_WEIGHT
    } step_kind_t;

    // One row of the directed table: a register write or a weight
    typedef struct {
        step_kind_t                      kind;
        logic [glr_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [glr_pkg::CFG_DATA_W-1:0]  reg_val;
        logic [glr_pkg::WEIGHT_W-1:0]    w;
        bit                              pinned;
        lap_elem_t                       elem;
    } stim_row_t;

    localparam lap_elem_t NO_ELEM     = '0;
    localparam lap_elem_t SOLO_ZERO   = '{22'sd0, 1'b1, 1'b1, 1'b0};
    localparam lap_elem_t SOLO_FLAG   = '{22'sd0, 1'b1, 1'b1, 1'b1};
    localparam lap_elem_t SOLO_UNITY  = '{22'sd65535, 1'b1, 1'b1, 1'b0};

    localparam int DIR_ROWS = 31;

    // Directed stimulus; pinned rows carry their expected element
    stim_row_t dir_tab [DIR_ROWS] = '{
        // single node, combinatorial: diagonal minus itself is zero
        '{ST_CFG,    glr_pkg::REG_NODE_COUNT, 6'd1,     16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h0000, 1'b1, SOLO_ZERO},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'hFFFF, 1'b1, SOLO_ZERO},
        // single node, random walk: zero degree flag and saturation of 1.0
        '{ST_CFG,    glr_pkg::REG_MODE,       CFG_RW,   16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h0000, 1'b1, SOLO_FLAG},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'hFFFF, 1'b1, SOLO_UNITY},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h0001, 1'b1, SOLO_UNITY},
        // node count of zero acts as one
        '{ST_CFG,    glr_pkg::REG_NODE_COUNT, 6'd0,     16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h8000, 1'b1, SOLO_UNITY},
        // two nodes, combinatorial, heaviest weights
        '{ST_CFG,    glr_pkg::REG_NODE_COUNT, 6'd2,     16'h0000, 1'b0, NO_ELEM},
        '{ST_CFG,    glr_pkg::REG_MODE,       CFG_COMB, 16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'hFFFF, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'hFFFF, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'hFFFF, 1'b0, NO_ELEM},
        // two nodes, random walk: a zero row then a lopsided row
        '{ST_CFG,    glr_pkg::REG_MODE,       CFG_RW,   16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h0001, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'hFFFF, 1'b0, NO_ELEM},
        // partial row dropped by a node count write
        '{ST_CFG,    glr_pkg::REG_NODE_COUNT, 6'd3,     16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h1234, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h00FF, 1'b0, NO_ELEM},
        '{ST_CFG,    glr_pkg::REG_NODE_COUNT, 6'd2,     16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'hAAAA, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h5555, 1'b0, NO_ELEM},
        // three nodes, combinatorial, alternating bit patterns
        '{ST_CFG,    glr_pkg::REG_NODE_COUNT, 6'd3,     16'h0000, 1'b0, NO_ELEM},
        '{ST_CFG,    glr_pkg::REG_MODE,       CFG_COMB, 16'h0000, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'hAAAA, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'h5555, 1'b0, NO_ELEM},
        '{ST_WEIGHT, glr_pkg::REG_NODE_COUNT, 6'd0,     16'hFFFF, 1'b0, NO_ELEM}
    };

    logic                                 clk;
    logic                                 rst_n       = 1'b0;
    logic                                 cfg_wr_en   = 1'b0;
    logic [glr_pkg::CFG_IDX_W-1:0]        cfg_index   = '0;
    logic [glr_pkg::CFG_DATA_W-1:0]       cfg_data    = '0;
    logic                                 in_valid    = 1'b0;
    logic                                 in_ready;
    logic [glr_pkg::WEIGHT_W-1:0]         weight      = '0;
    logic                                 out_valid;
    logic                                 out_ready   = 1'b0;
    logic signed [glr_pkg::VALUE_W-1:0]   value;
    logic                                 row_last;
    logic                                 matrix_last;
    logic                                 zero_degree;

    int send_idle_pct = 20;
    int recv_idle_pct = 59;
    int err_count     = 0;
    int stall_cycles  = 0;

    // Predictor state
    logic [glr_pkg::NODE_COUNT_W-1:0] lp_nodes = glr_pkg::NODE_COUNT_RESET;
    logic                             lp_mode  = glr_pkg::MODE_COMB;
    logic [glr_pkg::WEIGHT_W-1:0]     lp_row_w [glr_pkg::MAX_NODES];
    int unsigned                      lp_degree = 0;
    int unsigned                      lp_col    = 0;
    int unsigned                      lp_row    = 0;

    lap_elem_t row_elems [$];
    lap_elem_t pending_elems [$];

    graph_laplacian_row_engine_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .weight      (weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .row_last    (row_last),
        .matrix_last (matrix_last),
        .zero_degree (zero_degree)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Clamp the node count to the usable dimension
    function automatic int unsigned eff_nodes(input logic [glr_pkg::NODE_COUNT_W-1:0] nc);
        if (nc < 1)
            return 1;
        if (nc > glr_pkg::MAX_NODES)
            return glr_pkg::MAX_NODES;
        return nc;
    endfunction

    // Buffer one weight; on the last column emit the row into row_elems
    task automatic predict_laplacian(input logic [glr_pkg::WEIGHT_W-1:0] w);
        int unsigned     n;
        bit              last_row;
        int unsigned     diag;
        longint unsigned ratio;
        lap_elem_t       e;
        n = eff_nodes(lp_nodes);
        if (lp_col >= n)
        begin
            lp_col    = 0;
            lp_degree = 0;
        end
        if (lp_row >= n)
            lp_row = 0;
        lp_row_w[lp_col] = w;
        lp_degree += w;
        lp_col++;
        if (lp_col < n)
            return;
        last_row = (lp_row == n - 1);
        for (int j = 0; j < n; j++)
        begin
            e = '0;
            if (lp_mode == glr_pkg::MODE_COMB)
            begin
                diag    = (j == lp_row) ? lp_degree : 0;
                e.value = glr_pkg::VALUE_W'(diag) - glr_pkg::VALUE_W'(lp_row_w[j]);
            end
            else if (lp_degree == 0)
            begin
                e.zero_degree = 1'b1;
            end
            else
            begin
                ratio = (longint'(lp_row_w[j]) << 16) / longint'(lp_degree);
                if (ratio > 65535)
                    ratio = 65535;
                e.value = glr_pkg::VALUE_W'(ratio);
            end
            e.row_last    = (j == n - 1);
            e.matrix_last = last_row && (j == n - 1);
            row_elems.push_back(e);
        end
        lp_col    = 0;
        lp_degree = 0;
        lp_row    = last_row ? 0 : lp_row + 1;
    endtask

    // Present one weight transaction; starts and returns at a falling edge
    task automatic push_weight(input logic [glr_pkg::WEIGHT_W-1:0] w, input bit pinned,
                               input lap_elem_t pinned_elem);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        weight   <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_laplacian(w);
        if (pinned)
            pending_elems.push_back(pinned_elem);
        else
            foreach (row_elems[k])
                pending_elems.push_back(row_elems[k]);
        row_elems.delete();
        @(negedge clk);
    endtask

    // Write a register once the block has drained
    task automatic write_reg(input logic [glr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [glr_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_elems.size() != 0)
            @(negedge clk);
        repeat (CFG_PAUSE) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == glr_pkg::REG_NODE_COUNT)
        begin
            lp_nodes  = val;
            lp_col    = 0;
            lp_row    = 0;
            lp_degree = 0;
        end
        else
        begin
            lp_mode = val[0];
        end
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Check each output transaction against the oldest expected element
    always @(posedge clk)
    begin : result_check
        lap_elem_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_elems.size() == 0)
            begin
                $error("unexpected element: value %0d", value);
                err_count++;
            end
            else
            begin
                want = pending_elems.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, value);
                    err_count++;
                end
                if (row_last !== want.row_last)
                begin
                    $error("row_last: expected %0b, got %0b", want.row_last, row_last);
                    err_count++;
                end
                if (matrix_last !== want.matrix_last)
                begin
                    $error("matrix_last: expected %0b, got %0b",
                           want.matrix_last, matrix_last);
                    err_count++;
                end
                if (zero_degree !== want.zero_degree)
                begin
                    $error("zero_degree: expected %0b, got %0b",
                           want.zero_degree, zero_degree);
                    err_count++;
                end
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                           items_sent;
        int                           phase;
        int                           n_cfg;
        int                           n_eff;
        int                           rows;
        int                           style;
        int                           hot;
        int                           extra;
        logic [glr_pkg::WEIGHT_W-1:0] w;

        // Hold reset, then release it
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ST_CFG)
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            else
                push_weight(dir_tab[i].w, dir_tab[i].pinned, dir_tab[i].elem);
        end

        // Random matrices: mostly complete rows, some partial rows as noise
        items_sent = 0;
        phase      = 0;
        while (items_sent < RAND_ITEMS)
        begin
            if (phase == 0)
                n_cfg = 63;
            else if (phase == 1)
                n_cfg = 32;
            else
            begin
                case ($urandom_range(0, 15))
                    0:       n_cfg = 0;
                    1:       n_cfg = 32;
                    2:       n_cfg = $urandom_range(33, 63);
                    default: n_cfg = $urandom_range(1, 6);
                endcase
            end
            n_eff = eff_nodes(glr_pkg::NODE_COUNT_W'(n_cfg));
            write_reg(glr_pkg::REG_NODE_COUNT, glr_pkg::CFG_DATA_W'(n_cfg));
            write_reg(glr_pkg::REG_MODE, $urandom_range(0, 1) ? CFG_RW : CFG_COMB);
            rows = (n_eff >= 16) ? 1 : $urandom_range(1, 2 * n_eff + 1);
            for (int r = 0; r < rows && items_sent < RAND_ITEMS; r++)
            begin
                // Idle profile advances with the number of items sent
                if (items_sent < RAND_ITEMS / 3)
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 59;
                end
                else if (items_sent < 2 * RAND_ITEMS / 3)
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 20;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                style = $urandom_range(0, 5);
                hot   = $urandom_range(0, n_eff - 1);
                for (int c = 0; c < n_eff; c++)
                begin
                    case (style)
                        0: w = '0;
                        1: w = (c == hot) ? glr_pkg::WEIGHT_W'($urandom) : '0;
                        default:
                            case ($urandom_range(0, 7))
                                0:       w = '0;
                                1:       w = '1;
                                2:       w = glr_pkg::WEIGHT_W'($urandom_range(0, 255));
                                default: w = glr_pkg::WEIGHT_W'($urandom);
                            endcase
                    endcase
                    push_weight(w, 1'b0, NO_ELEM);
                    items_sent++;
                end
            end
            // Leave a partial row behind for the next node count write to drop
            if (n_eff > 1 && $urandom_range(0, 5) == 0)
            begin
                extra = $urandom_range(1, n_eff - 1);
                for (int k = 0; k < extra; k++)
                begin
                    push_weight(glr_pkg::WEIGHT_W'($urandom), 1'b0, NO_ELEM);
                    items_sent++;
                end
            end
            phase++;
        end

        // Drain and settle
        in_valid <= 1'b0;
        while (pending_elems.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
